// ===== hdl/ebla_pkg.sv =====
package ebla_pkg;

   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_SILENCE = 2'd2;

   localparam logic [1:0] REG_BAR_COUNT = 2'd0;
   localparam logic [1:0] REG_SMOOTHING = 2'd1;
   localparam logic [1:0] REG_DURATION  = 2'd2;

   localparam logic [5:0]  BAR_COUNT_RESET = 6'd16;
   localparam logic [15:0] SMOOTHING_RESET = 16'd16384;
   localparam logic [15:0] DURATION_RESET  = 16'd200;

   localparam logic [15:0] FULL_LEVEL     = 16'd32768;
   localparam logic [15:0] SNAP_SMOOTHING = 16'd32;
   localparam logic [15:0] MOVE_THRESHOLD = 16'd3;
   localparam logic [24:0] Q24_ONE        = 25'h1000000;
   // ceil(2^34 / 5): floor(a * RECIP_FIVE / 2^34) == floor(a / 5) for any 32-bit a.
   localparam logic [31:0] RECIP_FIVE     = 32'hCCCCCCCD;
   localparam int          QUOT_BITS      = 24;

   typedef struct packed {
      logic [1:0]  operation;
      logic [4:0]  band_index;
      logic [15:0] level;
      logic        last_band;
      logic [9:0]  elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [5:0]  bar_index;
      logic [15:0] bar_level;
      logic        any_active;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        animating;
      logic [15:0] time_ms;
      logic [15:0] target;
      logic [15:0] start;
      logic [15:0] shown;
   } bar_entry_type;

   typedef struct packed {
      logic [15:0] elapsed;
      logic [30:0] span;
      logic [15:0] diff;
   } ease_req_type;

   typedef enum logic [2:0] {
      CT_IDLE,
      CT_READ,
      CT_EVAL,
      CT_EASE,
      CT_EMIT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      EZ_IDLE,
      EZ_DIV,
      EZ_MID,
      EZ_MULA,
      EZ_MULB,
      EZ_MULC,
      EZ_CMP,
      EZ_FIN1,
      EZ_FIN2,
      EZ_FIN3,
      EZ_DONE
   } ease_state_type;

endpackage

// ===== hdl/eased_bar_level_animator.sv =====
// Eased bar level animator.
// Requests arrive on req_valid/req_ready with a req_type payload: a band sample retargets
// a left bar and its mirrored right bar, a silence request retargets every bar to zero, and
// a tick advances all animating bars along the ease curve and then returns one rsp_type
// result per bar, bars 0 to 2N-1 in order, the final one flagged with last.
// Registers are written over the APB port: bar count at 0x0, smoothing at 0x4 and base
// duration at 0x8; pready is always high and reads return the stored values.
// One request is handled at a time; req_ready is high only while the block is idle.
// All bar state lives in one memory with a registered read; each bar is read, updated and
// written back before the next one is read.
// A sample or silence request makes one update pass over the bars that it touches; a sample
// with last_band set also retargets the bars of every higher band to zero. A tick makes an
// update pass, sends each animating bar that has not yet reached its target through the ease
// unit (a restoring divider, bisection steps and the finish of the ease value), and then
// emits one result per bar.
// A stalled receiver simply holds the current result; nothing else advances meanwhile.
// Reset restores the default register values and marks every bar as zero and idle with
// no clearing pass; a write that changes the bar count does the same to the bars.
module eased_bar_level_animator import ebla_pkg::*; #(
   parameter int MAX_BANDS    = 32,
   parameter int BISECT_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int BAR_DEPTH = 2 * MAX_BANDS;
   localparam int BAR_AW    = $clog2(BAR_DEPTH);

   // Configuration registers.
   logic [5:0]  bar_count_ff, bar_count_in;
   logic [15:0] smoothing_ff, smoothing_in;
   logic [15:0] duration_ff, duration_in;
   logic        csr_write;
   logic [5:0]  n_raw, n_sat;
   logic        clear_bars;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign n_raw     = pwdata[5:0];
   assign n_sat     = (n_raw > 6'(MAX_BANDS)) ? 6'(MAX_BANDS) : n_raw;
   assign clear_bars = csr_write && (paddr[3:2] == REG_BAR_COUNT) && (n_raw != 6'd0)
                       && (n_sat != bar_count_ff);

   always_comb begin
      bar_count_in = bar_count_ff;
      smoothing_in = smoothing_ff;
      duration_in  = duration_ff;
      if (csr_write) begin
         case (paddr[3:2])
            REG_BAR_COUNT: if (n_raw != 6'd0) bar_count_in = n_sat;
            REG_SMOOTHING: smoothing_in = pwdata[15:0];
            REG_DURATION:  duration_in = pwdata[15:0];
            default:       bar_count_in = bar_count_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_BAR_COUNT: prdata = {26'd0, bar_count_ff};
         REG_SMOOTHING: prdata = {16'd0, smoothing_ff};
         REG_DURATION:  prdata = {16'd0, duration_ff};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bar_count_ff <= BAR_COUNT_RESET;
         smoothing_ff <= SMOOTHING_RESET;
         duration_ff  <= DURATION_RESET;
      end else begin
         bar_count_ff <= bar_count_in;
         smoothing_ff <= smoothing_in;
         duration_ff  <= duration_in;
      end
   end

   // Sequencer state.
   ctrl_state_type state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [4:0]    lo_ff, lo_in, hi_ff, hi_in, i_ff, i_in;
   logic          side_ff, side_in;
   logic          emit_ff, emit_in;
   logic          any_ff, any_in;
   logic [15:0]   goal_ff, goal_in;
   logic [9:0]    dt_ff, dt_in;
   logic [30:0]   span_ff, span_in;
   logic          snap_ff, snap_in;
   bar_entry_type ent_ff, ent_in;

   // Memory and ease unit connections.
   bar_entry_type rd_entry, wr_entry;
   logic          mem_rd_en, mem_wr_en;
   ease_req_type  ease_args;
   logic          ease_start, ease_done;
   logic [15:0]   ease_mag;

   // Decode.
   logic [5:0]  bar_w;
   logic [6:0]  right_w, mirror_w;
   logic        pass_end_w, band_ok_w;
   logic [15:0] goal_w, dist_target_w, dist_shown_w;
   logic        retarget_w;
   logic [16:0] el_sum_w;
   logic [15:0] el_w;
   logic        reached_w, up_w, ent_up_w, need_ease_w, step_w;
   logic [15:0] d_w, s_w;
   logic [31:0] span_full_w;

   assign right_w    = {1'b0, bar_count_ff} + {2'd0, i_ff};
   assign mirror_w   = {bar_count_ff, 1'b0} - 7'd1 - {2'd0, i_ff};
   assign bar_w      = !side_ff ? {1'b0, i_ff} : (emit_ff ? right_w[5:0] : mirror_w[5:0]);
   assign pass_end_w = side_ff && (i_ff == hi_ff);
   assign band_ok_w  = {1'b0, req_payload.band_index} < bar_count_ff;

   assign goal_w = (op_ff == OP_SAMPLE && i_ff == lo_ff) ? goal_ff : 16'd0;
   assign dist_target_w = (rd_entry.target >= goal_w) ? rd_entry.target - goal_w
                                                       : goal_w - rd_entry.target;
   assign dist_shown_w  = (rd_entry.shown >= goal_w) ? rd_entry.shown - goal_w
                                                      : goal_w - rd_entry.shown;
   assign retarget_w = rd_entry.animating ? (dist_target_w > MOVE_THRESHOLD)
                                          : (dist_shown_w > MOVE_THRESHOLD);

   assign el_sum_w  = {1'b0, rd_entry.time_ms} + {7'd0, dt_ff};
   assign el_w      = el_sum_w[16] ? 16'hFFFF : el_sum_w[15:0];
   assign reached_w = {el_w, 15'd0} >= span_ff;
   assign up_w      = rd_entry.target >= rd_entry.start;
   assign ent_up_w  = ent_ff.target >= ent_ff.start;

   assign need_ease_w = (state_ff == CT_EVAL) && (op_ff == OP_TICK) && rd_entry.animating
                        && !snap_ff && !reached_w;
   assign step_w = ((state_ff == CT_EVAL) && !need_ease_w)
                   || ((state_ff == CT_EASE) && ease_done)
                   || ((state_ff == CT_EMIT) && rsp_ready);

   assign d_w         = (duration_ff == 16'd0) ? 16'd1 : duration_ff;
   assign s_w         = (smoothing_ff > FULL_LEVEL) ? FULL_LEVEL : smoothing_ff;
   assign span_full_w = d_w * s_w;

   assign ease_start      = need_ease_w;
   assign ease_args.elapsed = el_w;
   assign ease_args.span  = span_ff;
   assign ease_args.diff  = up_w ? rd_entry.target - rd_entry.start
                                 : rd_entry.start - rd_entry.target;

   assign mem_rd_en = (state_ff == CT_READ);

   always_comb begin
      mem_wr_en = 1'b0;
      wr_entry  = ent_ff;
      if (state_ff == CT_EVAL) begin
         if (op_ff == OP_TICK) begin
            mem_wr_en          = rd_entry.animating && (snap_ff || reached_w);
            wr_entry.animating = 1'b0;
            wr_entry.time_ms   = snap_ff ? rd_entry.time_ms : el_w;
            wr_entry.target    = rd_entry.target;
            wr_entry.start     = rd_entry.start;
            wr_entry.shown     = rd_entry.target;
         end else begin
            mem_wr_en          = retarget_w;
            wr_entry.animating = 1'b1;
            wr_entry.time_ms   = 16'd0;
            wr_entry.target    = goal_w;
            wr_entry.start     = rd_entry.shown;
            wr_entry.shown     = rd_entry.shown;
         end
      end else if (state_ff == CT_EASE) begin
         mem_wr_en      = ease_done;
         wr_entry.shown = ent_up_w ? ent_ff.start + ease_mag : ent_ff.start - ease_mag;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CT_IDLE: begin
            if (req_valid) begin
               case (req_payload.operation)
                  OP_SAMPLE:  state_in = band_ok_w ? CT_READ : CT_IDLE;
                  OP_TICK:    state_in = CT_READ;
                  OP_SILENCE: state_in = CT_READ;
                  default:    state_in = CT_IDLE;
               endcase
            end
         end
         CT_READ: state_in = emit_ff ? CT_EMIT : CT_EVAL;
         CT_EVAL: begin
            if (need_ease_w) begin
               state_in = CT_EASE;
            end else if (pass_end_w) begin
               state_in = (op_ff == OP_TICK) ? CT_READ : CT_IDLE;
            end else begin
               state_in = CT_READ;
            end
         end
         CT_EASE: begin
            if (ease_done) begin
               state_in = pass_end_w ? CT_READ : CT_READ;
            end
         end
         CT_EMIT: begin
            if (rsp_ready) begin
               state_in = pass_end_w ? CT_IDLE : CT_READ;
            end
         end
         default: state_in = CT_IDLE;
      endcase
   end

   // Datapath registers.
   always_comb begin
      op_in   = op_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      i_in    = i_ff;
      side_in = side_ff;
      emit_in = emit_ff;
      any_in  = any_ff;
      goal_in = goal_ff;
      dt_in   = dt_ff;
      span_in = span_ff;
      snap_in = snap_ff;
      ent_in  = ent_ff;

      if (state_ff == CT_IDLE && req_valid) begin
         op_in   = req_payload.operation;
         lo_in   = (req_payload.operation == OP_SAMPLE) ? req_payload.band_index : 5'd0;
         hi_in   = (req_payload.operation == OP_SAMPLE && !req_payload.last_band)
                   ? req_payload.band_index : 5'(bar_count_ff - 6'd1);
         i_in    = lo_in;
         side_in = 1'b0;
         emit_in = 1'b0;
         any_in  = 1'b0;
         goal_in = (req_payload.level > FULL_LEVEL) ? FULL_LEVEL : req_payload.level;
         dt_in   = req_payload.elapsed_ms;
         span_in = span_full_w[30:0];
         snap_in = s_w <= SNAP_SMOOTHING;
      end

      if (state_ff == CT_EVAL) begin
         if (op_ff == OP_TICK && rd_entry.animating) begin
            any_in = 1'b1;
         end
         ent_in = '{animating: 1'b1, time_ms: el_w, target: rd_entry.target,
                    start: rd_entry.start, shown: rd_entry.shown};
      end

      if (step_w) begin
         if (pass_end_w) begin
            // After the update pass of a tick, walk the bars again in output order.
            emit_in = 1'b1;
            i_in    = lo_ff;
            side_in = 1'b0;
         end else if (i_ff == hi_ff) begin
            i_in    = lo_ff;
            side_in = 1'b1;
         end else begin
            i_in = i_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CT_IDLE;
         emit_ff  <= 1'b0;
         any_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         emit_ff  <= emit_in;
         any_ff   <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      i_ff    <= i_in;
      side_ff <= side_in;
      goal_ff <= goal_in;
      dt_ff   <= dt_in;
      span_ff <= span_in;
      snap_ff <= snap_in;
      ent_ff  <= ent_in;
   end

   assign req_ready = (state_ff == CT_IDLE);
   assign rsp_valid = (state_ff == CT_EMIT);
   assign rsp_payload.bar_index  = bar_w;
   assign rsp_payload.bar_level  = rd_entry.shown;
   assign rsp_payload.any_active = any_ff;
   assign rsp_payload.last       = pass_end_w;

   ebla_bar_mem #(
      .DEPTH(BAR_DEPTH)
   ) u_bar_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear_bars),
      .rd_en   (mem_rd_en),
      .rd_addr (bar_w[BAR_AW-1:0]),
      .rd_data (rd_entry),
      .wr_en   (mem_wr_en),
      .wr_addr (bar_w[BAR_AW-1:0]),
      .wr_data (wr_entry)
   );

   ebla_ease #(
      .BISECT_STEPS(BISECT_STEPS)
   ) u_ease (
      .clock     (clock),
      .reset     (reset),
      .start_req (ease_start),
      .args      (ease_args),
      .done      (ease_done),
      .mag       (ease_mag)
   );

   a_no_write_while_emitting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !mem_wr_en)
      else $error("bar memory written while a result is offered");

   a_idle_has_no_work: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid && !ease_done && !mem_wr_en))
      else $error("block reports ready while work is still in flight");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_payload.last) |=> req_ready)
      else $error("block did not return to idle after the final result of a tick");

   a_ease_done_in_ease: assert property (@(posedge clock) disable iff (reset)
      ease_done |-> (state_ff == CT_EASE))
      else $error("ease unit finished while the sequencer was not waiting for it");

endmodule

// ===== hdl/ebla_bar_mem.sv =====
module ebla_bar_mem import ebla_pkg::*; #(
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output bar_entry_type rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  bar_entry_type wr_data
);

   bar_entry_type      mem_ff [DEPTH];
   bar_entry_type      rd_ff;
   logic               rd_valid_ff;
   logic [DEPTH-1:0]   valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   // An entry never written since reset or a bar count change reads as all zero.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_ff : '0;

endmodule

// ===== hdl/ebla_ease.sv =====
module ebla_ease import ebla_pkg::*; #(
   parameter int BISECT_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start_req,
   input  ease_req_type args,
   output logic         done,
   output logic [15:0]  mag
);

   localparam int CW = $clog2(QUOT_BITS > BISECT_STEPS ? QUOT_BITS : BISECT_STEPS);

   ease_state_type state_ff, state_in;

   logic [30:0]   span_ff, span_in;
   logic [15:0]   diff_ff, diff_in;
   logic [30:0]   rem_ff, rem_in;
   logic [23:0]   quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [24:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [24:0]   t_ff, t_in, u_ff, u_in;
   logic [24:0]   uu_ff, uu_in, tt_ff, tt_in;
   logic [24:0]   u2t_ff, u2t_in, t3_ff, t3_in;
   logic [23:0]   d5_ff, d5_in;
   logic [24:0]   e_ff, e_in;
   logic [15:0]   mag_ff, mag_in;

   logic [24:0] mula_a, mula_b;
   logic [49:0] prod_a;
   logic [25:0] mulb_a;
   logic [31:0] mulb_b;
   logic [57:0] prod_b;

   logic [31:0] rem2_w;
   logic [25:0] mid_sum_w;
   logic [25:0] cx_w;
   logic [26:0] y_w;

   logic div_last_w, bis_last_w;

   assign div_last_w = (cnt_ff == CW'(QUOT_BITS - 1));
   assign bis_last_w = (cnt_ff == CW'(BISECT_STEPS - 1));

   assign prod_a = mula_a * mula_b;
   assign prod_b = mulb_a * mulb_b;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EZ_IDLE: if (start_req) state_in = EZ_DIV;
         EZ_DIV:  if (div_last_w) state_in = EZ_MID;
         EZ_MID:  state_in = EZ_MULA;
         EZ_MULA: state_in = EZ_MULB;
         EZ_MULB: state_in = EZ_MULC;
         EZ_MULC: state_in = EZ_CMP;
         EZ_CMP:  state_in = bis_last_w ? EZ_FIN1 : EZ_MID;
         EZ_FIN1: state_in = EZ_FIN2;
         EZ_FIN2: state_in = EZ_FIN3;
         EZ_FIN3: state_in = EZ_DONE;
         EZ_DONE: state_in = EZ_IDLE;
         default: state_in = EZ_IDLE;
      endcase
   end

   always_comb begin
      mula_a = '0;
      mula_b = '0;
      mulb_a = '0;
      mulb_b = '0;
      case (state_ff)
         EZ_MULA: begin
            mula_a = u_ff;
            mula_b = u_ff;
            mulb_a = {1'b0, t_ff};
            mulb_b = {7'd0, t_ff};
         end
         EZ_MULB: begin
            mula_a = uu_ff;
            mula_b = t_ff;
            mulb_a = {1'b0, tt_ff};
            mulb_b = {7'd0, t_ff};
         end
         EZ_MULC: begin
            mulb_a = {u2t_ff, 1'b0} + {1'b0, u2t_ff};
            mulb_b = RECIP_FIVE;
         end
         EZ_FIN1: begin
            mula_a = u_ff;
            mula_b = tt_ff;
         end
         EZ_FIN3: begin
            mula_a = {9'd0, diff_ff};
            mula_b = e_ff;
         end
         default: begin
            mula_a = '0;
         end
      endcase
   end

   always_comb begin
      span_in = span_ff;
      diff_in = diff_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      t_in    = t_ff;
      u_in    = u_ff;
      uu_in   = uu_ff;
      tt_in   = tt_ff;
      u2t_in  = u2t_ff;
      t3_in   = t3_ff;
      d5_in   = d5_ff;
      e_in    = e_ff;
      mag_in  = mag_ff;

      rem2_w    = {rem_ff, 1'b0};
      mid_sum_w = {1'b0, lo_ff} + {1'b0, hi_ff};
      cx_w      = {2'd0, d5_ff} + {1'b0, t3_ff};
      y_w       = {1'b0, uu_ff, 1'b0} + {2'd0, uu_ff} + {2'd0, t3_ff};

      case (state_ff)
         EZ_IDLE: begin
            if (start_req) begin
               span_in = args.span;
               diff_in = args.diff;
               rem_in  = {args.elapsed, 15'd0};
               quo_in  = '0;
               cnt_in  = '0;
            end
         end
         EZ_DIV: begin
            // Restoring division, one quotient bit a cycle; the remainder stays below span.
            if (rem2_w >= {1'b0, span_ff}) begin
               rem_in = rem2_w[30:0] - span_ff;
               quo_in = {quo_ff[22:0], 1'b1};
            end else begin
               rem_in = rem2_w[30:0];
               quo_in = {quo_ff[22:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (div_last_w) begin
               cnt_in = '0;
               lo_in  = '0;
               hi_in  = Q24_ONE;
            end
         end
         EZ_MID: begin
            t_in = mid_sum_w[25:1];
            u_in = Q24_ONE - mid_sum_w[25:1];
         end
         EZ_MULA: begin
            uu_in = prod_a[48:24];
            tt_in = prod_b[48:24];
         end
         EZ_MULB: begin
            u2t_in = prod_a[48:24];
            t3_in  = prod_b[48:24];
         end
         EZ_MULC: begin
            d5_in = prod_b[57:34];
         end
         EZ_CMP: begin
            if (cx_w < {2'd0, quo_ff}) begin
               lo_in = t_ff;
            end else begin
               hi_in = t_ff;
            end
            cnt_in = cnt_ff + 1'b1;
         end
         EZ_FIN1: begin
            uu_in = prod_a[48:24];
         end
         EZ_FIN2: begin
            e_in = (y_w > {2'd0, Q24_ONE}) ? Q24_ONE : y_w[24:0];
         end
         EZ_FIN3: begin
            mag_in = prod_a[39:24];
         end
         default: begin
            mag_in = mag_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EZ_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
      diff_ff <= diff_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      t_ff    <= t_in;
      u_ff    <= u_in;
      uu_ff   <= uu_in;
      tt_ff   <= tt_in;
      u2t_ff  <= u2t_in;
      t3_ff   <= t3_in;
      d5_ff   <= d5_in;
      e_ff    <= e_in;
      mag_ff  <= mag_in;
   end

   assign done = (state_ff == EZ_DONE);
   assign mag  = mag_ff;

endmodule
